>>> rtl/eol_pkg.sv
package eol_pkg;

  // Default build parameters.
  localparam int unsigned WINDOW_LEN_DEF  = 5;
  localparam int unsigned SAMPLE_BITS_DEF = 18;

  // Fixed-point constants: one in Q3.15 and the shift of the Q.29 divisor.
  localparam int unsigned ONE_Q15   = 32768;
  localparam int unsigned DIV_SHIFT = 29;

  // Configuration port and register widths.
  localparam int unsigned CFG_IDX_BITS  = 8;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned GAIN_BITS     = 16;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RUN       = 8'd0,
    REG_OVER_GAIN = 8'd1
  } cfg_reg_e;

endpackage

>>> rtl/eol_in_if.sv
interface eol_in_if #(
  parameter int unsigned SAMPLE_BITS = eol_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_i;
  logic signed [SAMPLE_BITS-1:0] in_q;

  modport source (output valid, output in_i, output in_q, input ready);
  modport sink   (input valid, input in_i, input in_q, output ready);
endinterface

>>> rtl/eol_out_if.sv
interface eol_out_if #(
  parameter int unsigned SAMPLE_BITS = eol_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_i;
  logic signed [SAMPLE_BITS-1:0] out_q;

  modport source (output valid, output out_i, output out_q, input ready);
  modport sink   (input valid, input out_i, input out_q, output ready);
endinterface

>>> rtl/eol_cfg_if.sv
interface eol_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [eol_pkg::CFG_IDX_BITS-1:0]   idx;
  logic [eol_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

>>> rtl/eol_ram.sv
module eol_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/eol_fifo.sv
module eol_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = eol_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push_i && !full_o) - CW'(pop_i && !empty_o);
    end
  end
endmodule

>>> rtl/eol_front.sv
module eol_front #(
  parameter int unsigned SAMPLE_BITS = eol_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned QW          = 1 + 3 * SAMPLE_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  eol_in_if.sink        in_smp,
  input  logic          run_i,
  output logic          push_o,
  output logic [QW-1:0] push_data_o,
  input  logic          full_i
);
  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned RW = SB + 2;
  localparam int unsigned CW = $clog2(SB);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_SQ   = 5'b00010,
    F_SUM  = 5'b00100,
    F_ROOT = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_e;

  fstate_e          state_q, state_d;
  logic [SB-1:0]    i_q, q_q, env_q;
  logic             pass_q;
  logic [2*SB-1:0]  sqi_q, sqq_q, rad_q;
  logic [RW-1:0]    rem_q;
  logic [SB-1:0]    root_q;
  logic [CW-1:0]    cnt_q;
  logic [SB-1:0]    mag_i, mag_q;
  logic [RW-1:0]    rem_sh, trial;
  logic             take;

  assign in_smp.ready = (state_q == F_IDLE);
  assign push_o       = (state_q == F_PUSH) && !full_i;
  assign push_data_o  = {pass_q, i_q, q_q, env_q};

  // Magnitudes of the stored sample.
  assign mag_i = i_q[SB-1] ? (~i_q + 1'b1) : i_q;
  assign mag_q = q_q[SB-1] ? (~q_q + 1'b1) : q_q;

  // One root bit per cycle.
  assign rem_sh = {rem_q[RW-3:0], rad_q[2*SB-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign take   = (rem_sh >= trial);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (in_smp.valid) state_d = run_i ? F_SQ : F_PUSH;
      F_SQ:   state_d = F_SUM;
      F_SUM:  state_d = F_ROOT;
      F_ROOT: if (cnt_q == CW'(SB - 1)) state_d = F_PUSH;
      F_PUSH: if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: squares, sum, then the bit-serial square root.
  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        i_q    <= in_smp.in_i;
        q_q    <= in_smp.in_q;
        pass_q <= !run_i;
        env_q  <= '0;
      end
      F_SQ: begin
        sqi_q <= mag_i * mag_i;
        sqq_q <= mag_q * mag_q;
      end
      F_SUM: begin
        rad_q  <= sqi_q + sqq_q;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
      end
      F_ROOT: begin
        rem_q  <= take ? (rem_sh - trial) : rem_sh;
        root_q <= {root_q[SB-2:0], take};
        rad_q  <= {rad_q[2*SB-3:0], 2'b00};
        cnt_q  <= cnt_q + 1'b1;
        env_q  <= {root_q[SB-2:0], take};
      end
      default: ;
    endcase
  end
endmodule

>>> rtl/eol_back.sv
module eol_back #(
  parameter int unsigned WINDOW_LEN  = eol_pkg::WINDOW_LEN_DEF,
  parameter int unsigned SAMPLE_BITS = eol_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned QW          = 1 + 3 * SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  output logic                          pop_o,
  input  logic [QW-1:0]                 pop_data_i,
  input  logic [eol_pkg::GAIN_BITS-1:0] gain_i,
  eol_out_if.source                     out_smp
);
  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned WL  = WINDOW_LEN;
  localparam int unsigned AW  = $clog2(WL);
  localparam int unsigned PW  = ((SB > 16) ? SB : 16) + 1;
  localparam int unsigned DW  = ((SB + 16 > 30) ? SB + 16 : 30) + 1;
  localparam int unsigned RMW = DW + 1;
  localparam int unsigned NW  = SB + eol_pkg::DIV_SHIFT;
  localparam int unsigned CW  = $clog2(SB);

  typedef enum logic [6:0] {
    B_IDLE    = 7'b0000001,
    B_LEAVE   = 7'b0000010,
    B_SCAN    = 7'b0000100,
    B_SCANEND = 7'b0001000,
    B_MUL     = 7'b0010000,
    B_DIV     = 7'b0100000,
    B_OUT     = 7'b1000000
  } bstate_e;

  bstate_e         state_q, state_d;
  logic [AW-1:0]   wslot_q, rslot_q, scan_q, last_q;
  logic [WL-1:0]   valid_q;
  logic            lvld_q, svld_q, pend_q;
  logic [SB-1:0]   peak_q, env_q;
  logic [SB-1:0]   oi_q, oq_q, outi_q, outq_q, qi_q, qq_q, lowi_q, lowq_q;
  logic            negi_q, negq_q;
  logic [DW-1:0]   d_q;
  logic [RMW-1:0]  remi_q, remq_q;
  logic [CW-1:0]   cnt_q;

  logic            pop_pass;
  logic [SB-1:0]   pop_i, pop_q, pop_env;
  logic            s_we, e_we;
  logic [AW-1:0]   e_raddr;
  logic [2*SB-1:0] s_rdata;
  logic [SB-1:0]   e_rdata;
  logic [SB-1:0]   leave, pk_new, scan_val, magi, magq;
  logic            rescan, over_one;
  logic [PW-1:0]   excess;
  logic [NW-1:0]   numi, numq;
  logic [RMW-1:0]  shi, shq, dext;
  logic            ti, tq;
  logic [SB-1:0]   qi_n, qq_n;

  // Unpack the queued item.
  assign pop_pass = pop_data_i[QW-1];
  assign pop_i    = pop_data_i[QW-2 -: SB];
  assign pop_q    = pop_data_i[QW-2-SB -: SB];
  assign pop_env  = pop_data_i[SB-1:0];
  assign pop_o    = (state_q == B_IDLE) && !empty_i;

  // Sample and envelope lines.
  assign s_we    = pop_o && !pop_pass;
  assign e_we    = (state_q == B_LEAVE);
  assign e_raddr = (state_q == B_SCAN) ? scan_q : wslot_q;

  eol_ram #(.WIDTH(2 * SB), .DEPTH(WL)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (wslot_q),
    .wdata_i ({pop_i, pop_q}),
    .raddr_i (rslot_q),
    .rdata_o (s_rdata)
  );

  eol_ram #(.WIDTH(SB), .DEPTH(WL)) u_env_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (wslot_q),
    .wdata_i (env_q),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  // Peak update and the decision to rescan.
  assign leave    = lvld_q ? e_rdata : '0;
  assign pk_new   = (env_q > peak_q) ? env_q : peak_q;
  assign rescan   = (leave >= pk_new) && (leave != '0);
  assign scan_val = valid_q[last_q] ? e_rdata : '0;

  // Divisor setup.
  assign over_one = (PW'(peak_q) > PW'(eol_pkg::ONE_Q15));
  assign excess   = PW'(peak_q) - PW'(eol_pkg::ONE_Q15);
  assign magi     = oi_q[SB-1] ? (~oi_q + 1'b1) : oi_q;
  assign magq     = oq_q[SB-1] ? (~oq_q + 1'b1) : oq_q;
  assign numi     = {magi, {eol_pkg::DIV_SHIFT{1'b0}}};
  assign numq     = {magq, {eol_pkg::DIV_SHIFT{1'b0}}};

  // Restoring division, one quotient bit per cycle for each lane.
  assign dext = RMW'(d_q);
  assign shi  = {remi_q[RMW-2:0], lowi_q[SB-1]};
  assign shq  = {remq_q[RMW-2:0], lowq_q[SB-1]};
  assign ti   = (shi >= dext);
  assign tq   = (shq >= dext);
  assign qi_n = {qi_q[SB-2:0], ti};
  assign qq_n = {qq_q[SB-2:0], tq};

  assign out_smp.valid = (state_q == B_OUT);
  assign out_smp.out_i = outi_q;
  assign out_smp.out_q = outq_q;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:    if (!empty_i) state_d = pop_pass ? B_OUT : B_LEAVE;
      B_LEAVE:   state_d = rescan ? B_SCAN : B_MUL;
      B_SCAN:    if (scan_q == AW'(WL - 1)) state_d = B_SCANEND;
      B_SCANEND: state_d = B_MUL;
      B_MUL:     state_d = over_one ? B_DIV : B_OUT;
      B_DIV:     if (cnt_q == CW'(SB - 1)) state_d = B_OUT;
      B_OUT:     if (out_smp.ready) state_d = B_IDLE;
      default:   state_d = B_IDLE;
    endcase
  end

  // Window control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      wslot_q <= '0;
      rslot_q <= AW'(WL / 2);
      valid_q <= '0;
      peak_q  <= '0;
    end else begin
      state_q <= state_d;
      if (s_we) begin
        valid_q[wslot_q] <= 1'b1;
      end
      if (state_q == B_LEAVE) begin
        peak_q  <= rescan ? '0 : pk_new;
        wslot_q <= (wslot_q == '0) ? AW'(WL - 1) : wslot_q - 1'b1;
        rslot_q <= (rslot_q == '0) ? AW'(WL - 1) : rslot_q - 1'b1;
      end
      if ((state_q == B_SCAN || state_q == B_SCANEND) && pend_q && scan_val > peak_q) begin
        peak_q <= scan_val;
      end
    end
  end

  // Item datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        env_q  <= pop_env;
        outi_q <= pop_i;
        outq_q <= pop_q;
        lvld_q <= valid_q[wslot_q];
        svld_q <= valid_q[rslot_q];
      end
      B_LEAVE: begin
        oi_q   <= svld_q ? s_rdata[2*SB-1 -: SB] : '0;
        oq_q   <= svld_q ? s_rdata[SB-1:0] : '0;
        scan_q <= '0;
        pend_q <= 1'b0;
      end
      B_SCAN: begin
        pend_q <= 1'b1;
        last_q <= scan_q;
        scan_q <= scan_q + 1'b1;
      end
      B_MUL: begin
        d_q    <= DW'(64'd1 << eol_pkg::DIV_SHIFT) + DW'(gain_i * excess);
        remi_q <= RMW'(numi[NW-1:SB]);
        remq_q <= RMW'(numq[NW-1:SB]);
        lowi_q <= numi[SB-1:0];
        lowq_q <= numq[SB-1:0];
        negi_q <= oi_q[SB-1];
        negq_q <= oq_q[SB-1];
        qi_q   <= '0;
        qq_q   <= '0;
        cnt_q  <= '0;
        outi_q <= oi_q;
        outq_q <= oq_q;
      end
      B_DIV: begin
        remi_q <= ti ? (shi - dext) : shi;
        remq_q <= tq ? (shq - dext) : shq;
        lowi_q <= {lowi_q[SB-2:0], 1'b0};
        lowq_q <= {lowq_q[SB-2:0], 1'b0};
        qi_q   <= qi_n;
        qq_q   <= qq_n;
        cnt_q  <= cnt_q + 1'b1;
        outi_q <= negi_q ? (~qi_n + 1'b1) : qi_n;
        outq_q <= negq_q ? (~qq_n + 1'b1) : qq_n;
      end
      default: ;
    endcase
  end

  // A peak kept without a rescan covers the new envelope.
  a_peak_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_LEAVE && !rescan) |=> (peak_q >= env_q))
    else $error("peak below new envelope");

  // A pass-through item leaves the window untouched.
  a_pass_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && pop_pass) |=> ($stable(wslot_q) && $stable(valid_q) && $stable(peak_q)))
    else $error("pass-through item changed window state");

  // The divisor is at least one and the remainders stay below it.
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV) |-> (d_q >= DW'(64'd1 << eol_pkg::DIV_SHIFT)
                            && remi_q < dext && remq_q < dext))
    else $error("divider out of range");
endmodule

>>> rtl/envelope_overshoot_limiter_unit.sv
// Overshoot limiter for controlled-envelope SSB. Each I/Q request returns one
// I/Q request. With run set, the sample enters a WINDOW_LEN-deep line, its
// truncated magnitude is tracked as a window peak, and the sample from
// WINDOW_LEN/2 requests earlier is divided by 1 + over_gain*(peak - 1) when
// the peak exceeds one. With run clear, samples pass unchanged. The front
// computes the magnitude, with run set, by a bit-serial square root, hands the
// request to a two-entry queue, waiting while it is full, and takes a new
// request only once that hand-off is done. The back pops the request,
// updates the window peak, rescans the envelope line one entry a cycle when
// the peak leaves the window, sets up the divisor, runs the restoring divider
// when the peak exceeds one, and holds the result until it is taken. Front
// and back overlap through the queue, so the front can work on a new request
// while the back finishes the last. Write configuration only while the block
// is idle.
module envelope_overshoot_limiter_unit #(
  parameter int unsigned WINDOW_LEN  = eol_pkg::WINDOW_LEN_DEF,
  parameter int unsigned SAMPLE_BITS = eol_pkg::SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  eol_cfg_if.sink   cfg_i,
  eol_in_if.sink    in_smp_i,
  eol_out_if.source out_smp_o
);
  localparam int unsigned QW = 1 + 3 * SAMPLE_BITS;

  logic                          run_q;
  logic [eol_pkg::GAIN_BITS-1:0] gain_q;
  logic                          push, full, pop, empty;
  logic [QW-1:0]                 push_data, pop_data;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      gain_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.idx)
        eol_pkg::REG_RUN:       run_q  <= cfg_i.data[0];
        eol_pkg::REG_OVER_GAIN: gain_q <= cfg_i.data[eol_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  eol_front #(.SAMPLE_BITS(SAMPLE_BITS), .QW(QW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_smp      (in_smp_i),
    .run_i       (run_q),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  eol_fifo #(.WIDTH(QW), .DEPTH(eol_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  eol_back #(.WINDOW_LEN(WINDOW_LEN), .SAMPLE_BITS(SAMPLE_BITS), .QW(QW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pop_o      (pop),
    .pop_data_i (pop_data),
    .gain_i     (gain_q),
    .out_smp    (out_smp_o)
  );
endmodule

>>> tb/envelope_overshoot_limiter_unit_tb.sv
module envelope_overshoot_limiter_unit_tb;

  localparam int unsigned WLEN  = eol_pkg::WINDOW_LEN_DEF;
  localparam int unsigned SBITS = eol_pkg::SAMPLE_BITS_DEF;

  typedef struct packed {
    logic signed [SBITS-1:0] i;
    logic signed [SBITS-1:0] q;
  } iq_t;

  typedef struct packed {
    logic                              is_cfg;
    eol_pkg::cfg_reg_e                 idx;
    logic [eol_pkg::CFG_DATA_BITS-1:0] data;
    iq_t                               smp;
  } job_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  eol_cfg_if              cfg_if ();
  eol_in_if  #(SBITS)     in_if  ();
  eol_out_if #(SBITS)     out_if ();

  envelope_overshoot_limiter_unit #(.WINDOW_LEN(WLEN), .SAMPLE_BITS(SBITS)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .in_smp_i (in_if),
    .out_smp_o(out_if)
  );

  always #5 clk_i = ~clk_i;

  // Limiter state mirrored for prediction.
  iq_t                           line_smp [WLEN];
  logic [SBITS-1:0]              line_env [WLEN];
  int unsigned                   wr_slot;
  int unsigned                   rd_slot;
  logic [SBITS-1:0]              peak_env;
  logic                          run_en;
  logic [eol_pkg::GAIN_BITS-1:0] gain;

  job_t pending_jobs[$];
  iq_t  expected_smp[$];
  int   fail_cnt = 0;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [SBITS-1:0] shrink(longint s, longint unsigned d);
    longint unsigned m;
    longint unsigned qv;
    m = (s < 0) ? longint'(-s) : longint'(s);
    qv = (m << eol_pkg::DIV_SHIFT) / d;
    return (s < 0) ? SBITS'(-longint'(qv)) : SBITS'(longint'(qv));
  endfunction

  // Compute the expected output sample for one accepted request.
  function automatic iq_t limit_sample(iq_t s);
    longint          si;
    longint          sq;
    longint unsigned e;
    longint unsigned d;
    logic [SBITS-1:0] leaving;
    iq_t             o;
    if (!run_en) return s;
    si = s.i;
    sq = s.q;
    line_smp[wr_slot] = s;
    leaving = line_env[wr_slot];
    e = int_sqrt(longint'(si * si) + longint'(sq * sq));
    line_env[wr_slot] = SBITS'(e);
    if (SBITS'(e) > peak_env) peak_env = SBITS'(e);
    if (leaving >= peak_env && leaving > 0) begin
      peak_env = 0;
      for (int j = 0; j < WLEN; j++)
        if (line_env[j] > peak_env) peak_env = line_env[j];
    end
    o = line_smp[rd_slot];
    if (peak_env > eol_pkg::ONE_Q15) begin
      d = (64'd1 << eol_pkg::DIV_SHIFT)
          + longint'(gain) * (longint'(peak_env) - eol_pkg::ONE_Q15);
      o.i = shrink(longint'(o.i), d);
      o.q = shrink(longint'(o.q), d);
    end
    wr_slot = (wr_slot == 0) ? WLEN - 1 : wr_slot - 1;
    rd_slot = (rd_slot == 0) ? WLEN - 1 : rd_slot - 1;
    return o;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: takes jobs from the pending queue, waits for idle before a write.
  int   drv_gap = 0;
  logic cfg_wait = 1'b0;
  int   drain_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        expected_smp.push_back(limit_sample('{i: in_if.in_i, q: in_if.in_q}));
      end
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.idx == eol_pkg::REG_RUN) run_en <= cfg_if.data[0];
        else if (cfg_if.idx == eol_pkg::REG_OVER_GAIN)
          gain <= cfg_if.data[eol_pkg::GAIN_BITS-1:0];
      end
      if ((in_if.valid && !in_if.ready) || (cfg_if.valid && !cfg_if.ready)) begin
        // Hold the current request.
      end else if (drv_gap > 0) begin
        drv_gap <= drv_gap - 1;
        in_if.valid <= 1'b0;
        cfg_if.valid <= 1'b0;
      end else if (pending_jobs.size() == 0) begin
        in_if.valid <= 1'b0;
        cfg_if.valid <= 1'b0;
      end else if (pending_jobs[0].is_cfg) begin
        in_if.valid <= 1'b0;
        if (!(expected_smp.size() == 0 && !(in_if.valid && in_if.ready)
              && !out_if.valid)) begin
          drain_cnt <= 0;
          cfg_if.valid <= 1'b0;
        end else if (drain_cnt < 80) begin
          drain_cnt <= drain_cnt + 1;
          cfg_if.valid <= 1'b0;
        end else begin
          drain_cnt <= 0;
          cfg_if.valid <= 1'b1;
          cfg_if.idx <= pending_jobs[0].idx;
          cfg_if.data <= pending_jobs[0].data;
          void'(pending_jobs.pop_front());
        end
      end else begin
        cfg_if.valid <= 1'b0;
        in_if.valid <= 1'b1;
        in_if.in_i <= pending_jobs[0].smp.i;
        in_if.in_q <= pending_jobs[0].smp.q;
        void'(pending_jobs.pop_front());
        drv_gap <= gap_len();
      end
    end
  end

  // Monitor: checks each accepted output and applies random backpressure.
  int stall_cnt = 0;
  always @(posedge clk_i) begin
    iq_t exp_s;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_smp.size() == 0) begin
          $error("unexpected output i=%0d q=%0d", out_if.out_i, out_if.out_q);
          fail_cnt++;
        end else begin
          exp_s = expected_smp.pop_front();
          if (out_if.out_i !== exp_s.i) begin
            $error("out_i expected %0d actual %0d", exp_s.i, out_if.out_i);
            fail_cnt++;
          end
          if (out_if.out_q !== exp_s.q) begin
            $error("out_q expected %0d actual %0d", exp_s.q, out_if.out_q);
            fail_cnt++;
          end
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_if.ready <= 1'b0;
      end else begin
        stall_cnt <= gap_len();
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic add_cfg(eol_pkg::cfg_reg_e r, logic [eol_pkg::CFG_DATA_BITS-1:0] v);
    job_t j;
    j = '0;
    j.is_cfg = 1'b1;
    j.idx = r;
    j.data = v;
    pending_jobs.push_back(j);
  endtask

  task automatic add_smp(logic [SBITS-1:0] a, logic [SBITS-1:0] b);
    job_t j;
    j = '0;
    j.smp.i = a;
    j.smp.q = b;
    pending_jobs.push_back(j);
  endtask

  // Random sample: half mid-range, some full scale, some near zero.
  task automatic add_rand_smp();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) add_smp(SBITS'($urandom_range(0, 65535) - 32768),
                       SBITS'($urandom_range(0, 65535) - 32768));
    else if (r < 8) add_smp(SBITS'($urandom), SBITS'($urandom));
    else add_smp(SBITS'($urandom_range(0, 15) - 8), SBITS'($urandom_range(0, 15) - 8));
  endtask

  initial begin
    logic [SBITS-1:0] mx;
    logic [SBITS-1:0] mn;
    logic [eol_pkg::CFG_DATA_BITS-1:0] gains[4];
    mx = {1'b0, {(SBITS-1){1'b1}}};
    mn = {1'b1, {(SBITS-1){1'b0}}};
    gains = '{32'd0, 32'hFFFF, 32'h0000_4000, 32'hFFFF_0001};
    cfg_if.valid = 1'b0;
    cfg_if.idx = eol_pkg::REG_RUN;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.in_i = '0;
    in_if.in_q = '0;
    out_if.ready = 1'b0;
    for (int k = 0; k < WLEN; k++) begin
      line_smp[k] = '0;
      line_env[k] = '0;
    end
    wr_slot = 0;
    rd_slot = WLEN / 2;
    peak_env = '0;
    run_en = 1'b0;
    gain = '0;

    // Directed: pass-through first, then limiting with extreme samples, then zero gain and run clear.
    add_smp(mx, mn);
    add_smp(mn, mx);
    add_cfg(eol_pkg::REG_OVER_GAIN, 32'hFFFF);
    add_cfg(eol_pkg::REG_RUN, 32'h1);
    add_smp(mx, mx);
    add_smp(mn, mn);
    add_smp(0, 0);
    add_smp(SBITS'(32768), 0);
    add_smp(SBITS'(32769), 0);
    add_smp(0, 0);
    add_smp(1, -1);
    for (int k = 0; k < 6; k++) add_smp(0, 0);
    add_smp(mn, 0);
    add_smp(0, mx);
    add_cfg(eol_pkg::REG_OVER_GAIN, 32'h0);
    add_smp(mx, mn);
    add_smp(mn, mx);
    add_cfg(eol_pkg::REG_RUN, 32'hFFFF_FFFE);
    add_smp(SBITS'(12345), SBITS'(-54321));

    // Random phases with varied register settings.
    for (int p = 0; p < 14; p++) begin
      add_cfg(eol_pkg::REG_RUN, (p % 5 == 4) ? 32'h0 : {$urandom} | 32'h1);
      add_cfg(eol_pkg::REG_OVER_GAIN, (p < 4) ? gains[p] : $urandom);
      for (int k = 0; k < 100; k++) add_rand_smp();
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_jobs.size() == 0);
    @(posedge clk_i);
    while (expected_smp.size() != 0 || in_if.valid) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && expected_smp.size() == 0) begin
      $display("envelope_overshoot_limiter_unit verification clean");
    end else begin
      $display("envelope_overshoot_limiter_unit verification failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("envelope_overshoot_limiter_unit verification failed");
    $finish;
  end

endmodule
